// ===== src/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion helpers, clocked on clk with reset arst_n
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// property must hold at every clock edge out of reset
`define ASSERT_CLKED(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("assertion failed");
// expression must never be true out of reset
`define ASSERT_NEVER(label, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error("forbidden condition seen");
`else
`define ASSERT_CLKED(label, prop)
`define ASSERT_NEVER(label, expr)
`endif

`endif

// ===== src/vna_pkg.sv =====
// ---------------------------------------------------------------------------
// vna_pkg
// shared types and constants of the vertex normal accumulator
// ---------------------------------------------------------------------------
package vna_pkg;

	localparam int DEF_MAX_VERTICES = 4096;
	localparam int IDX_W = 12;
	localparam int POS_W = 32;
	localparam int VEC_W = 3 * POS_W;
	localparam int Q_W = 17;
	localparam int MAG_W = 31;

	typedef enum logic [1:0] {
		CMD_LOAD = 2'd0,
		CMD_TRI  = 2'd1,
		CMD_QUAD = 2'd2,
		CMD_READ = 2'd3
	} cmd_t;

	typedef enum logic [4:0] {
		S_CLR,
		S_IDLE,
		S_RDN,
		S_PA,
		S_PB,
		S_PC,
		S_PE,
		S_EDGE,
		S_SCL,
		S_MUL,
		S_NRM0,
		S_NRM,
		S_SQ,
		S_DIV,
		S_ACR,
		S_ACW,
		S_OUT
	} state_t;

endpackage

// ===== src/vertex_normal_accumulator.sv =====
// load: accepted while idle, stores the position and clears the normal sum; read: stored normal sum
// face: edges and cross product (a degenerate face goes straight to output), then the
// bit-serial square root (32 steps), the 17-step divide and a normal read and write per in-range corner
// one item at a time; a finished result waits in the output register
// after reset the normal memory is cleared over all MAX_VERTICES entries, input not ready
`include "assert_macros.svh"
// ---------------------------------------------------------------------------
// vertex_normal_accumulator
// position and normal-sum memories, face normal and per-corner accumulation
// ---------------------------------------------------------------------------
module vertex_normal_accumulator import vna_pkg::*; #(
	parameter int MAX_VERTICES = DEF_MAX_VERTICES
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// vertex_index, pos_x, pos_y, pos_z, corner_a, corner_b, corner_c, corner_d, pad
	input  logic [159:0] s_tdata,
	// cmd
	input  logic [1:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// normal_x, normal_y, normal_z
	output logic [95:0]  m_tdata,
	// degenerate
	output logic [0:0]   m_tuser
);

	localparam int AW = $clog2(MAX_VERTICES);

	state_t state_q, state_d;

	logic [VEC_W-1:0] pos_mem [MAX_VERTICES];
	logic [VEC_W-1:0] nrm_mem [MAX_VERTICES];
	logic [VEC_W-1:0] pos_rd_q, nrm_rd_q;
	logic             pos_we, nrm_we;
	logic [AW-1:0]    pos_wa, pos_ra, nrm_wa, nrm_ra;
	logic [VEC_W-1:0] pos_wd, nrm_wd;

	logic [AW-1:0]    clr_cnt_q;
	logic             s_xfer;
	cmd_t             in_cmd;
	logic [IDX_W-1:0] in_idx;
	logic             in_rng;

	cmd_t             cmd_q;
	logic [IDX_W-1:0] idx_q;
	logic [IDX_W-1:0] corner_q [4];
	logic [1:0]       ci_q;
	logic [IDX_W-1:0] cur_corner;
	logic             cur_rng;
	logic             last_c;

	logic signed [31:0] pa_q [3];
	logic signed [31:0] pb_q [3];
	logic signed [31:0] pc_q [3];
	logic signed [32:0] e_q [6];
	logic [32:0]        emag [6];
	logic [1:0]         esh;
	logic signed [31:0] es_q [6];
	logic [2:0]         mstep_q;
	logic [2:0]         jdx;
	logic signed [31:0] mul_a, mul_b;
	logic signed [63:0] prod_q;
	logic signed [63:0] cr_q [3];
	logic               sgn_q [3];
	logic [61:0]        mg_q [3];
	logic [61:0]        mor;
	logic [63:0]        sq_sum_q;
	logic               dv_start, dv_done;
	logic [MAG_W-1:0]   dv_mag [3];
	logic [Q_W-1:0]     dv_quot [3];

	logic signed [31:0] nv_q [3];
	logic               deg_q;
	logic [95:0]        m_tdata_q;
	logic               m_tuser_q;
	logic               m_tvalid_q;
	logic               out_free;
	logic [32:0]        acc_sum [3];
	logic [31:0]        acc_sat [3];

	function automatic logic idx_ok(input logic [IDX_W-1:0] idx);
		return 32'(idx) < 32'(MAX_VERTICES);
	endfunction

	assign s_xfer   = s_tvalid && s_tready;
	assign in_cmd   = cmd_t'(s_tuser);
	assign in_idx   = s_tdata[11:0];
	assign in_rng   = idx_ok(in_idx);
	assign out_free = !m_tvalid_q || m_tready;

	assign cur_corner = corner_q[ci_q];
	assign cur_rng    = idx_ok(cur_corner);
	assign last_c     = (cmd_q == CMD_QUAD) ? (ci_q == 2'd3) : (ci_q == 2'd2);
	assign jdx        = mstep_q - 3'd1;
	assign mor        = mg_q[0] | mg_q[1] | mg_q[2];

	// edge magnitudes and the common right shift that brings them to at most 2^30
	always_comb begin
		esh = 2'd0;
		for (int i = 0; i < 6; i++) begin
			emag[i] = e_q[i][32] ? 33'(-e_q[i]) : 33'(e_q[i]);
			if (emag[i] > 33'h0_8000_0001) begin
				esh = 2'd2;
			end else if (emag[i] > 33'h0_4000_0000 && esh == 2'd0) begin
				esh = 2'd1;
			end
		end
	end

	// shared multiplier operands: cross product terms, then squares
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		if (state_q == S_MUL) begin
			case (mstep_q)
				3'd0: begin mul_a = es_q[1]; mul_b = es_q[5]; end
				3'd1: begin mul_a = es_q[2]; mul_b = es_q[4]; end
				3'd2: begin mul_a = es_q[2]; mul_b = es_q[3]; end
				3'd3: begin mul_a = es_q[0]; mul_b = es_q[5]; end
				3'd4: begin mul_a = es_q[0]; mul_b = es_q[4]; end
				3'd5: begin mul_a = es_q[1]; mul_b = es_q[3]; end
				default: begin mul_a = '0; mul_b = '0; end
			endcase
		end else begin
			case (mstep_q)
				3'd0: mul_a = $signed({1'b0, mg_q[0][30:0]});
				3'd1: mul_a = $signed({1'b0, mg_q[1][30:0]});
				3'd2: mul_a = $signed({1'b0, mg_q[2][30:0]});
				default: mul_a = '0;
			endcase
			mul_b = mul_a;
		end
	end

	// saturating add of the face normal onto a corner sum
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			acc_sum[i] = {nrm_rd_q[32*i+31], nrm_rd_q[32*i +: 32]} + {nv_q[i][31], nv_q[i]};
			if (acc_sum[i][32] != acc_sum[i][31]) begin
				acc_sat[i] = acc_sum[i][32] ? 32'h8000_0000 : 32'h7fff_ffff;
			end else begin
				acc_sat[i] = acc_sum[i][31:0];
			end
			dv_mag[i] = mg_q[i][MAG_W-1:0];
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLR: if (clr_cnt_q == AW'(MAX_VERTICES - 1)) state_d = S_IDLE;
			S_IDLE: begin
				if (s_xfer) begin
					unique case (in_cmd) inside
						CMD_LOAD: state_d = S_OUT;
						CMD_READ: state_d = S_RDN;
						CMD_TRI, CMD_QUAD: state_d = S_PA;
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_RDN:  state_d = S_OUT;
			S_PA:   state_d = S_PB;
			S_PB:   state_d = S_PC;
			S_PC:   state_d = S_PE;
			S_PE:   state_d = S_EDGE;
			S_EDGE: state_d = S_SCL;
			S_SCL:  state_d = S_MUL;
			S_MUL:  if (mstep_q == 3'd6) state_d = S_NRM0;
			S_NRM0: begin
				if (cr_q[0] == '0 && cr_q[1] == '0 && cr_q[2] == '0) state_d = S_OUT;
				else state_d = S_NRM;
			end
			S_NRM:  if (mor[61:30] == 32'd1) state_d = S_SQ;
			S_SQ:   if (mstep_q == 3'd4) state_d = S_DIV;
			S_DIV:  if (dv_done) state_d = S_ACR;
			S_ACR: begin
				if (cur_rng) state_d = S_ACW;
				else if (last_c) state_d = S_OUT;
			end
			S_ACW:  state_d = last_c ? S_OUT : S_ACR;
			S_OUT:  if (out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		s_tready = (state_q == S_IDLE);
		dv_start = (state_q == S_SQ) && (mstep_q == 3'd4);
		pos_we   = s_xfer && (in_cmd == CMD_LOAD) && in_rng;
		pos_wa   = AW'(in_idx);
		pos_wd   = s_tdata[107:12];
		pos_ra   = '0;
		nrm_we   = 1'b0;
		nrm_wa   = AW'(in_idx);
		nrm_wd   = '0;
		nrm_ra   = AW'(cur_corner);
		unique case (state_q)
			S_CLR: begin
				nrm_we = 1'b1;
				nrm_wa = clr_cnt_q;
			end
			S_IDLE: begin
				nrm_we = pos_we;
				nrm_ra = AW'(in_idx);
			end
			S_PA: pos_ra = AW'(corner_q[0]);
			S_PB: pos_ra = AW'(corner_q[1]);
			S_PC: pos_ra = AW'(corner_q[2]);
			S_ACW: begin
				nrm_we = 1'b1;
				nrm_wa = AW'(cur_corner);
				nrm_wd = {acc_sat[2], acc_sat[1], acc_sat[0]};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (pos_we) pos_mem[pos_wa] <= pos_wd;
		pos_rd_q <= pos_mem[pos_ra];
	end

	always_ff @(posedge clk) begin
		if (nrm_we) nrm_mem[nrm_wa] <= nrm_wd;
		nrm_rd_q <= nrm_mem[nrm_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLR;
			clr_cnt_q  <= '0;
			m_tvalid_q <= 1'b0;
			mstep_q    <= '0;
			ci_q       <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLR) clr_cnt_q <= clr_cnt_q + AW'(1);
			if (state_q == S_OUT && out_free) m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
			if (state_q == S_MUL || state_q == S_SQ) mstep_q <= mstep_q + 3'd1;
			else mstep_q <= '0;
			if (state_q == S_DIV) ci_q <= '0;
			else if ((state_q == S_ACR && !cur_rng) || state_q == S_ACW) ci_q <= ci_q + 2'd1;
		end
	end

	vna_sqrt_div u_sqrt_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (dv_start),
		.sum_sq (sq_sum_q),
		.mag    (dv_mag),
		.done   (dv_done),
		.quot   (dv_quot)
	);

	// datapath registers
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		case (state_q)
			S_IDLE: begin
				cmd_q       <= in_cmd;
				idx_q       <= in_idx;
				corner_q[0] <= s_tdata[119:108];
				corner_q[1] <= s_tdata[131:120];
				corner_q[2] <= s_tdata[143:132];
				corner_q[3] <= s_tdata[155:144];
				deg_q       <= 1'b0;
				for (int i = 0; i < 3; i++) nv_q[i] <= '0;
			end
			S_RDN: begin
				for (int i = 0; i < 3; i++)
					nv_q[i] <= idx_ok(idx_q) ? $signed(nrm_rd_q[32*i +: 32]) : '0;
			end
			S_PB: for (int i = 0; i < 3; i++)
				pa_q[i] <= idx_ok(corner_q[0]) ? $signed(pos_rd_q[32*i +: 32]) : '0;
			S_PC: for (int i = 0; i < 3; i++)
				pb_q[i] <= idx_ok(corner_q[1]) ? $signed(pos_rd_q[32*i +: 32]) : '0;
			S_PE: for (int i = 0; i < 3; i++)
				pc_q[i] <= idx_ok(corner_q[2]) ? $signed(pos_rd_q[32*i +: 32]) : '0;
			S_EDGE: begin
				for (int i = 0; i < 3; i++) begin
					e_q[i]     <= {pa_q[i][31], pa_q[i]} - {pb_q[i][31], pb_q[i]};
					e_q[3 + i] <= {pc_q[i][31], pc_q[i]} - {pb_q[i][31], pb_q[i]};
				end
			end
			S_SCL: begin
				for (int i = 0; i < 6; i++)
					es_q[i] <= e_q[i][32] ? 32'(-(emag[i] >> esh)) : 32'(emag[i] >> esh);
				for (int i = 0; i < 3; i++) cr_q[i] <= '0;
			end
			S_MUL: begin
				if (mstep_q != 3'd0) begin
					if (jdx[0]) cr_q[jdx[2:1]] <= cr_q[jdx[2:1]] - prod_q;
					else cr_q[jdx[2:1]] <= cr_q[jdx[2:1]] + prod_q;
				end
			end
			S_NRM0: begin
				for (int i = 0; i < 3; i++) begin
					sgn_q[i] <= cr_q[i][63];
					mg_q[i]  <= cr_q[i][63] ? 62'(-cr_q[i]) : 62'(cr_q[i]);
				end
				deg_q <= (cr_q[0] == '0 && cr_q[1] == '0 && cr_q[2] == '0);
				sq_sum_q <= '0;
			end
			S_NRM: begin
				// bring the largest magnitude into [2^30, 2^31), truncating downward
				for (int i = 0; i < 3; i++) begin
					if (mor[61:39] != '0) mg_q[i] <= mg_q[i] >> 8;
					else if (mor[38:31] != '0) mg_q[i] <= mg_q[i] >> 1;
					else if (mor[29:22] == '0 && !mor[30]) mg_q[i] <= mg_q[i] << 8;
					else if (!mor[30]) mg_q[i] <= mg_q[i] << 1;
				end
			end
			S_SQ: begin
				if (mstep_q != 3'd0 && mstep_q != 3'd4)
					sq_sum_q <= sq_sum_q + $unsigned(prod_q);
			end
			S_DIV: begin
				for (int i = 0; i < 3; i++)
					nv_q[i] <= sgn_q[i] ? -$signed({15'b0, dv_quot[i]})
						: $signed({15'b0, dv_quot[i]});
			end
			default: ;
		endcase
		if (state_q == S_OUT && out_free) begin
			m_tdata_q <= {nv_q[2], nv_q[1], nv_q[0]};
			m_tuser_q <= deg_q;
		end
	end

	assign m_tvalid   = m_tvalid_q;
	assign m_tdata    = m_tdata_q;
	assign m_tuser[0] = m_tuser_q;

	`ASSERT_NEVER(a_no_xfer_in_clear, state_q == S_CLR && s_tready)
	`ASSERT_CLKED(a_div_done_in_div, dv_done |-> state_q == S_DIV)
	`ASSERT_CLKED(a_deg_zero, (state_q == S_OUT && deg_q) |-> (nv_q[0] == '0 && nv_q[1] == '0 && nv_q[2] == '0))
	`ASSERT_CLKED(a_acc_not_deg, state_q == S_ACW |-> !deg_q)

endmodule

// ===== src/vna_sqrt_div.sv =====
// ---------------------------------------------------------------------------
// vna_sqrt_div
// integer square root of the squared length, then three rounded divides
// ---------------------------------------------------------------------------
module vna_sqrt_div import vna_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [63:0]      sum_sq,
	input  logic [MAG_W-1:0] mag [3],
	output logic             done,
	output logic [Q_W-1:0]   quot [3]
);

	logic        sq_busy_q;
	logic        setup_q;
	logic        dv_busy_q;
	logic        done_q;
	logic [4:0]  cnt_q;
	logic [63:0] rem_q;
	logic [63:0] root_q;
	logic [63:0] bit_q;
	logic [64:0] trial;
	logic        take;
	logic [33:0] dvs_q;
	logic [33:0] drem_q [3];
	logic [Q_W-1:0] lo_q [3];
	logic [Q_W-1:0] quot_q [3];
	logic [48:0] num [3];
	logic [34:0] rtry [3];

	assign trial = {1'b0, root_q} + {1'b0, bit_q};
	assign take  = ({1'b0, rem_q} >= trial);

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			num[i]  = {1'b0, mag[i], 17'b0} + {16'b0, root_q[32:0]};
			rtry[i] = {drem_q[i], lo_q[i][Q_W-1]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_busy_q <= 1'b0;
			setup_q   <= 1'b0;
			dv_busy_q <= 1'b0;
			done_q    <= 1'b0;
			cnt_q     <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				sq_busy_q <= 1'b1;
				cnt_q     <= '0;
			end else if (sq_busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					sq_busy_q <= 1'b0;
					setup_q   <= 1'b1;
				end
			end else if (setup_q) begin
				setup_q   <= 1'b0;
				dv_busy_q <= 1'b1;
				cnt_q     <= '0;
			end else if (dv_busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'(Q_W - 1)) begin
					dv_busy_q <= 1'b0;
					done_q    <= 1'b1;
				end
			end
		end
	end

	// one result bit per cycle for the root, one quotient bit per cycle per lane
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= sum_sq;
			root_q <= '0;
			bit_q  <= 64'h4000_0000_0000_0000;
		end else if (sq_busy_q) begin
			if (take) begin
				rem_q  <= rem_q - trial[63:0];
				root_q <= (root_q >> 1) + bit_q;
			end else begin
				root_q <= root_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
		if (setup_q) begin
			dvs_q <= {root_q[32:0], 1'b0};
			for (int i = 0; i < 3; i++) begin
				drem_q[i] <= {2'b0, num[i][48:17]};
				lo_q[i]   <= num[i][Q_W-1:0];
				quot_q[i] <= '0;
			end
		end else if (dv_busy_q) begin
			for (int i = 0; i < 3; i++) begin
				if (rtry[i] >= {1'b0, dvs_q}) begin
					drem_q[i] <= 34'(rtry[i] - {1'b0, dvs_q});
					quot_q[i] <= {quot_q[i][Q_W-2:0], 1'b1};
				end else begin
					drem_q[i] <= rtry[i][33:0];
					quot_q[i] <= {quot_q[i][Q_W-2:0], 1'b0};
				end
				lo_q[i] <= {lo_q[i][Q_W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule
